// ----- design/jsu_pkg.sv -----
package jsu_pkg;

  localparam int GRP_DEPTH = 4;
  localparam int CNT_W     = $clog2(GRP_DEPTH + 1);
  localparam int IDX_W     = $clog2(GRP_DEPTH);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_BODY = 5'b00010,
    MODE_ESC  = 5'b00100,
    MODE_HEX  = 5'b01000,
    MODE_DONE = 5'b10000
  } mode_t;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_CLOSE = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    res_t [GRP_DEPTH-1:0]   res;
  } grp_t;

  // only the low 12 bits of the gathered code point feed later digits
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  hex_cnt;
    logic [11:0] cp;
  } dec_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic res_t mk_res(input logic [7:0] d, input status_t s);
    res_t r;
    r.data   = d;
    r.status = s;
    return r;
  endfunction

endpackage

// ----- design/jsu_ifs.sv -----
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ----- design/jsu_dec.sv -----
module jsu_dec
  import jsu_pkg::*;
(
  input  dec_state_t cur,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output dec_state_t nxt,
  output grp_t       grp
);

  always_comb begin
    logic [CNT_W-1:0] n;
    hex_t             hv;
    logic [15:0]      cp16;

    nxt  = cur;
    grp  = '0;
    n    = '0;
    hv   = hex_val(text_byte);
    cp16 = {cur.cp, hv.val};

    case (cur.mode)
      MODE_IDLE: begin
        if (text_byte == CH_QUOTE) begin
          nxt.mode = MODE_BODY;
        end else begin
          grp.res[n[IDX_W-1:0]] = mk_res(8'h00, ST_ERROR);
          n = n + 1'b1;
          nxt.mode = MODE_DONE;
        end
      end
      MODE_BODY: begin
        if (text_byte == CH_QUOTE) begin
          grp.res[n[IDX_W-1:0]] = mk_res(8'h00, ST_CLOSE);
          n = n + 1'b1;
          nxt.mode = MODE_DONE;
        end else if (text_byte == CH_BSLASH) begin
          nxt.mode = MODE_ESC;
        end else begin
          grp.res[n[IDX_W-1:0]] = mk_res(text_byte, ST_BYTE);
          n = n + 1'b1;
        end
      end
      MODE_ESC: begin
        nxt.mode = MODE_BODY;
        case (text_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            grp.res[n[IDX_W-1:0]] = mk_res(text_byte, ST_BYTE);
            n = n + 1'b1;
          end
          CH_B: begin
            grp.res[n[IDX_W-1:0]] = mk_res(CTL_BS, ST_BYTE);
            n = n + 1'b1;
          end
          CH_F: begin
            grp.res[n[IDX_W-1:0]] = mk_res(CTL_FF, ST_BYTE);
            n = n + 1'b1;
          end
          CH_N: begin
            grp.res[n[IDX_W-1:0]] = mk_res(CTL_LF, ST_BYTE);
            n = n + 1'b1;
          end
          CH_R: begin
            grp.res[n[IDX_W-1:0]] = mk_res(CTL_CR, ST_BYTE);
            n = n + 1'b1;
          end
          CH_T: begin
            grp.res[n[IDX_W-1:0]] = mk_res(CTL_HT, ST_BYTE);
            n = n + 1'b1;
          end
          CH_U: begin
            nxt.mode    = MODE_HEX;
            nxt.hex_cnt = '0;
            nxt.cp      = '0;
          end
          default: begin
            grp.res[n[IDX_W-1:0]] = mk_res(8'h00, ST_ERROR);
            n = n + 1'b1;
            nxt.mode = MODE_DONE;
          end
        endcase
      end
      MODE_HEX: begin
        if (!hv.ok) begin
          grp.res[n[IDX_W-1:0]] = mk_res(8'h00, ST_ERROR);
          n = n + 1'b1;
          nxt.mode = MODE_DONE;
        end else if (cur.hex_cnt == 2'd3) begin
          // UTF-8, one to three bytes
          if (cp16[15:7] == '0) begin
            grp.res[n[IDX_W-1:0]] = mk_res({1'b0, cp16[6:0]}, ST_BYTE);
            n = n + 1'b1;
          end else if (cp16[15:11] == '0) begin
            grp.res[n[IDX_W-1:0]] = mk_res({3'b110, cp16[10:6]}, ST_BYTE);
            n = n + 1'b1;
            grp.res[n[IDX_W-1:0]] = mk_res({2'b10, cp16[5:0]}, ST_BYTE);
            n = n + 1'b1;
          end else begin
            grp.res[n[IDX_W-1:0]] = mk_res({4'b1110, cp16[15:12]}, ST_BYTE);
            n = n + 1'b1;
            grp.res[n[IDX_W-1:0]] = mk_res({2'b10, cp16[11:6]}, ST_BYTE);
            n = n + 1'b1;
            grp.res[n[IDX_W-1:0]] = mk_res({2'b10, cp16[5:0]}, ST_BYTE);
            n = n + 1'b1;
          end
          nxt.mode    = MODE_BODY;
          nxt.hex_cnt = '0;
          nxt.cp      = '0;
        end else begin
          nxt.cp      = cp16[11:0];
          nxt.hex_cnt = cur.hex_cnt + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (end_of_text) begin
      if (nxt.mode inside {MODE_BODY, MODE_ESC, MODE_HEX}) begin
        grp.res[n[IDX_W-1:0]] = mk_res(8'h00, ST_ERROR);
        n = n + 1'b1;
      end
      nxt.mode    = MODE_IDLE;
      nxt.hex_cnt = '0;
      nxt.cp      = '0;
    end

    grp.cnt = n;
  end

endmodule

// ----- design/json_string_unescape.sv -----
// channel | dir | fields                       | handshake
// in_chan | in  | text_byte[8], end_of_text    | valid/ready
// out_chan| out | out_byte[8], status[2], last | valid/ready
//
// One text byte decoded per cycle while in_chan.ready is high, into a group
// register of up to four words. The next byte is taken in the cycle the last
// word of the group leaves; bytes giving none, or one, stream at one per cycle
// when the output is ready. Synchronous active-low reset returns to idle with
// the output empty. Output stalls back-pressure the input through in_chan.ready.
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);

  dec_state_t        st_r, st_nxt;
  grp_t              grp_r, dec_grp;
  logic              grp_vld_r, grp_vld_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_last, take, take_last, acc;

  jsu_dec u_dec (
    .cur         (st_r),
    .text_byte   (in_chan.text_byte),
    .end_of_text (in_chan.end_of_text),
    .nxt         (st_nxt),
    .grp         (dec_grp)
  );

  assign out_last  = ({1'b0, idx_r} == grp_r.cnt - 1'b1);
  assign take      = grp_vld_r && out_chan.ready;
  assign take_last = take && out_last;
  assign in_chan.ready = !grp_vld_r || take_last;
  assign acc       = in_chan.valid && in_chan.ready;

  assign out_chan.valid    = grp_vld_r;
  assign out_chan.out_byte = grp_r.res[idx_r].data;
  assign out_chan.status   = grp_r.res[idx_r].status;
  assign out_chan.last     = out_last;

  always_comb begin
    grp_vld_nxt = grp_vld_r;
    idx_nxt     = idx_r;
    if (acc && dec_grp.cnt != '0) begin
      grp_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (take_last) begin
      grp_vld_nxt = 1'b0;
      idx_nxt     = '0;
    end else if (take) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode    <= MODE_IDLE;
      st_r.hex_cnt <= '0;
      st_r.cp      <= '0;
      grp_vld_r    <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (acc) begin
        st_r <= st_nxt;
      end
      grp_vld_r <= grp_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && dec_grp.cnt != '0) begin
      grp_r <= dec_grp;
    end
  end

endmodule

// ----- design/jsu_chk.sv -----
module jsu_chk
  import jsu_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] status,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(last))
    else $error("out word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_BYTE || status == ST_CLOSE || status == ST_ERROR)
    else $error("undefined status code");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_BYTE |-> last)
    else $error("close or error word not last of its group");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_BYTE |-> out_byte == 8'h00)
    else $error("close or error word carries data");

endmodule

bind json_string_unescape jsu_chk u_jsu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .status    (out_chan.status),
  .last      (out_chan.last)
);

// ----- bench/json_string_unescape_tb.sv -----
module json_string_unescape_tb
  import jsu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 340;
  localparam int IDLE_LIMIT   = 3000;
  localparam int SETTLE       = 20;

  typedef struct {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } decoded_word_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_chan();
  jsu_out_if out_chan();

  json_string_unescape uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // decoder shadow state
  mode_t       dec_mode  = MODE_IDLE;
  logic [1:0]  hex_seen  = 2'd0;
  logic [15:0] cp_acc    = 16'd0;

  decoded_word_t pending_words[$];
  decoded_word_t step_words[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  bit  steady     = 1'b0;

  logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    if (c == CH_U) return 1'b1;
    foreach (esc_letters[i]) if (esc_letters[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic emit_word(input logic [7:0] d, input status_t s);
    step_words.push_back(decoded_word_t'{d, s, 1'b0});
  endtask

  task automatic emit_utf8(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      emit_word(cp[7:0], ST_BYTE);
    end else if (cp < 16'h0800) begin
      emit_word({3'b110, cp[10:6]}, ST_BYTE);
      emit_word({2'b10, cp[5:0]}, ST_BYTE);
    end else begin
      emit_word({4'b1110, cp[15:12]}, ST_BYTE);
      emit_word({2'b10, cp[11:6]}, ST_BYTE);
      emit_word({2'b10, cp[5:0]}, ST_BYTE);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [4:0] hn;
    step_words.delete();
    case (dec_mode)
      MODE_IDLE: begin
        if (b == CH_QUOTE) begin
          dec_mode = MODE_BODY;
        end else begin
          emit_word(8'h00, ST_ERROR);
          dec_mode = MODE_DONE;
        end
      end
      MODE_BODY: begin
        if (b == CH_QUOTE) begin
          emit_word(8'h00, ST_CLOSE);
          dec_mode = MODE_DONE;
        end else if (b == CH_BSLASH) begin
          dec_mode = MODE_ESC;
        end else begin
          emit_word(b, ST_BYTE);
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_BODY;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: emit_word(b, ST_BYTE);
          CH_B: emit_word(CTL_BS, ST_BYTE);
          CH_F: emit_word(CTL_FF, ST_BYTE);
          CH_N: emit_word(CTL_LF, ST_BYTE);
          CH_R: emit_word(CTL_CR, ST_BYTE);
          CH_T: emit_word(CTL_HT, ST_BYTE);
          CH_U: begin
            dec_mode = MODE_HEX;
            hex_seen = 2'd0;
            cp_acc   = 16'd0;
          end
          default: begin
            emit_word(8'h00, ST_ERROR);
            dec_mode = MODE_DONE;
          end
        endcase
      end
      MODE_HEX: begin
        hn = hex_nibble(b);
        if (!hn[4]) begin
          emit_word(8'h00, ST_ERROR);
          dec_mode = MODE_DONE;
        end else begin
          cp_acc = {cp_acc[11:0], hn[3:0]};
          if (hex_seen == 2'd3) begin
            emit_utf8(cp_acc);
            hex_seen = 2'd0;
            cp_acc   = 16'd0;
            dec_mode = MODE_BODY;
          end else begin
            hex_seen = hex_seen + 2'd1;
          end
        end
      end
      default: ;
    endcase
    if (eot) begin
      if (dec_mode == MODE_BODY || dec_mode == MODE_ESC || dec_mode == MODE_HEX)
        emit_word(8'h00, ST_ERROR);
      dec_mode = MODE_IDLE;
      hex_seen = 2'd0;
      cp_acc   = 16'd0;
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    decode_byte(b, eot);
    in_chan.valid       <= 1'b1;
    in_chan.text_byte   <= b;
    in_chan.end_of_text <= eot;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    foreach (txt[i]) send_word(txt[i], i == txt.size() - 1);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic add_hex_digits(ref logic [7:0] txt[$], input int n);
    repeat (n) txt.push_back(hex_char(4'($urandom_range(0, 15))));
  endtask

  task automatic add_piece(ref logic [7:0] txt[$]);
    logic [7:0]  b;
    logic [15:0] cp;
    case ($urandom_range(0, 3))
      0, 1: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        txt.push_back(b);
      end
      2: begin
        txt.push_back(CH_BSLASH);
        txt.push_back(esc_letters[$urandom_range(0, 7)]);
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_U);
        for (int k = 3; k >= 0; k--) txt.push_back(hex_char(cp[k*4 +: 4]));
      end
    endcase
  endtask

  task automatic add_junk(ref logic [7:0] txt[$], input int n);
    repeat (n) txt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic random_text();
    logic [7:0] txt[$];
    logic [7:0] b;
    logic [4:0] hn;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
      txt.push_back(b);
      add_junk(txt, $urandom_range(0, 4));
    end else begin
      txt.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 8)) add_piece(txt);
      if (kind < 70) begin
        txt.push_back(CH_QUOTE);
        add_junk(txt, $urandom_range(0, 2));
      end else if (kind < 80) begin
        txt.push_back(CH_BSLASH);
        do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
        txt.push_back(b);
        add_junk(txt, $urandom_range(0, 2));
      end else if (kind < 88) begin
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_U);
        add_hex_digits(txt, $urandom_range(0, 3));
        do begin
          b  = 8'($urandom_range(0, 255));
          hn = hex_nibble(b);
        end while (hn[4]);
        txt.push_back(b);
        add_junk(txt, $urandom_range(0, 2));
      end else begin
        case ($urandom_range(0, 2))
          0: ;
          1: txt.push_back(CH_BSLASH);
          default: begin
            txt.push_back(CH_BSLASH);
            txt.push_back(CH_U);
            add_hex_digits(txt, $urandom_range(0, 3));
          end
        endcase
      end
    end
    send_text(txt);
  endtask

  task automatic test_missing_quote();
    logic [7:0] txt[$];
    txt = '{8'h5A, CH_QUOTE};
    send_text(txt);
  endtask

  task automatic test_escapes_and_close();
    logic [7:0] txt[$];
    txt = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_BSLASH, CH_U, 8'h46, 8'h66, 8'h66, 8'h46,
            CH_QUOTE, 8'h00};
    send_text(txt);
  endtask

  task automatic test_raw_and_bad_escape();
    logic [7:0] txt[$];
    txt = '{CH_QUOTE, 8'h00, 8'hFF, CH_BSLASH, 8'h71, 8'h78};
    send_text(txt);
  endtask

  task automatic test_bad_hex();
    logic [7:0] txt[$];
    txt = '{CH_QUOTE, CH_BSLASH, CH_U, 8'h30, 8'h67};
    send_text(txt);
  endtask

  task automatic test_open_at_end();
    logic [7:0] txt[$];
    // three UTF-8 bytes then the error, all from the final byte
    txt = '{CH_QUOTE, CH_BSLASH, CH_U, 8'h32, 8'h30, 8'h41, 8'h43};
    send_text(txt);
    txt = '{CH_QUOTE};
    send_text(txt);
    txt = '{CH_QUOTE, CH_BSLASH};
    send_text(txt);
  endtask

  task automatic test_random();
    int start;
    int texts;
    start = bytes_sent;
    texts = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      steady = (texts >= 25 && texts < 45);
      if (texts == 15 || $urandom_range(0, 99) < 3) drain_results();
      random_text();
      texts++;
    end
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int run;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      run = pick_gap();
      if (run > 0) begin
        out_chan.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    decoded_word_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_byte %0h status %0d last %0b",
               out_chan.out_byte, out_chan.status, out_chan.last);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_chan.status);
          mismatches++;
        end
        if (out_chan.out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_chan.out_byte);
          mismatches++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_chan.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL json_string_unescape");
        $finish;
      end
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.text_byte   <= 8'h00;
    in_chan.end_of_text <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_missing_quote();
    test_escapes_and_close();
    test_raw_and_bad_escape();
    test_bad_hex();
    test_open_at_end();
    test_random();

    in_chan.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS json_string_unescape");
    end else begin
      $display("FAIL json_string_unescape");
    end
    $finish;
  end

endmodule
